@@ rtl/core/string_key_bucket_hash_macros.svh @@
// Assertion macros shared by the hash block.
`ifndef STRING_KEY_BUCKET_HASH_MACROS_SVH
`define STRING_KEY_BUCKET_HASH_MACROS_SVH
// Implication checked every clock outside reset.
`define SKBH_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// Next-cycle implication checked outside reset.
`define SKBH_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

@@ rtl/core/skbh_pkg.sv @@
// ----------------------------------------------------------------------------
// skbh_pkg
// Shared constants and types of the key bucket hash.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package skbh_pkg;
  localparam int unsigned LENGTH_BITS_DEF = 16;
  localparam logic [31:0] NUM_BUCKETS_RST = 32'd83231;
  localparam logic [31:0] P1 = 32'h9E3779B1;
  localparam logic [31:0] P2 = 32'h85EBCA77;
  localparam logic [31:0] P3 = 32'hC2B2AE3D;
  localparam logic [31:0] P4 = 32'h27D4EB2F;
  localparam logic [31:0] P5 = 32'h165667B1;

  // Multiplier operation selects.
  typedef enum logic [2:0] {
    OP_LANE  = 3'd0,  // lane round: acc + w*P2, then rotl13 * P1
    OP_WORD  = 3'd1,  // tail word: h + w*P3, rotl17 * P4
    OP_BYTE  = 3'd2,  // tail byte: h + b*P5, rotl11 * P1
    OP_AV1   = 3'd3,  // h ^= h>>15; h *= P2
    OP_AV2   = 3'd4   // h ^= h>>13; h *= P3
  } mop_t;

  typedef struct packed {
    logic       load_byte;   // accept one key byte
    logic       fin_start;   // begin digest (latch h init)
    logic       mul_a;       // first half of a multiply op
    logic       mul_b;       // second half
    mop_t       op;
    logic [1:0] lane;
    logic       tail_adv;    // advance tail pointer by op size
    logic       av_last;     // final xor, latch digest
    logic       mod_start;
    logic       mod_step;
    logic       key_clear;
  } cmd_t;

  typedef struct packed {
    logic [3:0] fill;
    logic [3:0] tail_p;
    logic       stripe_full;
    logic       mod_done;
    logic       want_mod;
  } sts_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned r);
    rotl = (x << r) | (x >> (32 - r));
  endfunction
endpackage

@@ rtl/core/skbh_datapath.sv @@
// ----------------------------------------------------------------------------
// skbh_datapath
// Stripe buffer, lane accumulators, shared multiplier and radix-2 modulo.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "string_key_bucket_hash_macros.svh"
module skbh_datapath import skbh_pkg::*; #(
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [7:0]  byte_i,
  input  logic [15:0] len_i,
  input  logic [31:0] num_buckets,
  output logic [31:0] idx_o,
  output logic [31:0] dig_o,
  output logic        err_o
);
  localparam logic [LENGTH_BITS-1:0] LMAX = '1;

  logic [7:0]  sbuf [16];
  logic [31:0] acc_r [4];
  logic [LENGTH_BITS-1:0] seen_r;
  logic [7:0]  first_r, mid_r, lastb_r;
  logic [3:0]  fill_r, tp_r;
  logic        big_r, ovf_r, err_r, empty_r, stripe_r;
  logic [31:0] h_r, prod_r, dig_r;
  logic [LENGTH_BITS-1:0] klen;
  logic [44:0] c_r;
  logic [32:0] rem_r;
  logic [5:0]  mbit_r;

  assign klen = LENGTH_BITS'(len_i);

  function automatic logic [31:0] word_at(input logic [3:0] i);
    word_at = {sbuf[i+4'd3], sbuf[i+4'd2], sbuf[i+4'd1], sbuf[i]};
  endfunction

  // multiplier operands
  logic [31:0] ma, mb, pre, hx;
  always_comb begin
    ma = word_at(tp_r); mb = P3;
    hx = h_r;
    unique case (cmd.op)
      OP_LANE: begin ma = word_at({cmd.lane, 2'b00}); mb = P2; end
      OP_WORD: begin ma = word_at(tp_r); mb = P3; end
      OP_BYTE: begin ma = {24'd0, sbuf[tp_r]}; mb = P5; end
      OP_AV1:  begin hx = h_r ^ (h_r >> 15); ma = hx; mb = P2; end
      OP_AV2:  begin hx = h_r ^ (h_r >> 13); ma = hx; mb = P3; end
      default: ;
    endcase
    if (cmd.mul_b) begin
      mb = (cmd.op == OP_WORD) ? P4 : P1;
      unique case (cmd.op)
        OP_LANE: ma = rotl(prod_r, 13);
        OP_WORD: ma = rotl(prod_r, 17);
        default: ma = rotl(prod_r, 11);
      endcase
    end
  end
  logic [31:0] mres;
  assign mres = 32'(ma * mb);
  assign pre = (cmd.op == OP_LANE) ? acc_r[cmd.lane] : h_r;

  logic [31:0] hinit;
  assign hinit = (big_r ? (rotl(acc_r[0], 1) + rotl(acc_r[1], 7) + rotl(acc_r[2], 12)
                 + rotl(acc_r[3], 18)) : P5) + 32'(seen_r);

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.key_clear) begin
      acc_r[0] <= P1 + P2; acc_r[1] <= P2; acc_r[2] <= '0; acc_r[3] <= 32'd0 - P1;
      seen_r <= '0; first_r <= '0; mid_r <= '0; fill_r <= '0;
      big_r <= 1'b0; ovf_r <= 1'b0; stripe_r <= 1'b0;
    end else begin
      if (cmd.load_byte) begin
        lastb_r <= byte_i;
        if (klen != '0) begin
          if (seen_r == '0 && !ovf_r) first_r <= byte_i;
          if (!ovf_r && seen_r == (klen >> 1)) mid_r <= byte_i;
          sbuf[fill_r] <= byte_i;
          fill_r <= fill_r + 4'd1;
          // 16th byte closes a stripe; lane rounds are due
          if (fill_r == 4'd15) stripe_r <= 1'b1;
          if (seen_r == LMAX) ovf_r <= 1'b1;
          else seen_r <= seen_r + 1'b1;
        end
      end
      if (cmd.mul_b && cmd.op == OP_LANE) begin
        acc_r[cmd.lane] <= mres;
        if (cmd.lane == 2'd3) begin
          big_r <= 1'b1;
          stripe_r <= 1'b0;
        end
      end
    end
    if (!rst_n) dig_r <= '0;
    else if (cmd.av_last) dig_r <= h_r ^ (h_r >> 16);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_byte) begin
      err_r <= ovf_r || (klen != '0 && seen_r == LMAX) ||
               ((klen != '0 ? seen_r + 1'b1 : seen_r) != klen);
      empty_r <= (klen == '0);
    end
    if (cmd.fin_start) begin h_r <= hinit; tp_r <= '0; end
    if (cmd.mul_a) begin
      if (cmd.op == OP_AV1 || cmd.op == OP_AV2) h_r <= mres;
      else prod_r <= pre + mres;
    end
    if (cmd.mul_b && cmd.op != OP_LANE) h_r <= mres;
    if (cmd.tail_adv) tp_r <= tp_r + ((cmd.op == OP_WORD) ? 4'd4 : 4'd1);
    if (cmd.av_last)
      c_r <= 45'(({37'd0, first_r} * 45'd961 + {37'd0, mid_r} * 45'd31 + {37'd0, lastb_r})
             * 45'd31) + {13'd0, h_r ^ (h_r >> 16)};
    if (cmd.mod_start) begin rem_r <= '0; mbit_r <= 6'd44; end
    if (cmd.mod_step) begin
      logic [33:0] t;
      t = {rem_r, c_r[mbit_r]};
      if (t >= {2'b00, num_buckets}) t = t - {2'b00, num_buckets};
      rem_r <= t[32:0];
      mbit_r <= mbit_r - 6'd1;
    end
  end

  assign sts.fill = fill_r;
  assign sts.tail_p = tp_r;
  assign sts.stripe_full = stripe_r;
  assign sts.mod_done = (mbit_r == 6'd63);
  assign sts.want_mod = !(err_r || empty_r || num_buckets == '0);
  assign idx_o = (err_r || empty_r || num_buckets == '0) ? '0 : rem_r[31:0];
  assign dig_o = dig_r;
  assign err_o = err_r;

  `SKBH_ASSERT_IMP(a_fill_range, clk, rst_n, cmd.tail_adv, tp_r < fill_r || fill_r == 4'd0, "tail past fill")
  `SKBH_ASSERT_NEXT(a_clear, clk, rst_n, cmd.key_clear, seen_r == '0 && fill_r == 4'd0, "clear failed")
  `SKBH_ASSERT_IMP(a_rem, clk, rst_n, cmd.mod_step && num_buckets != '0, rem_r < {1'b0, num_buckets}, "rem out of range")
endmodule

@@ rtl/core/skbh_ctrl.sv @@
// ----------------------------------------------------------------------------
// skbh_ctrl
// Sequencer: byte intake, stripe rounds, tail, avalanche, modulo, output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "string_key_bucket_hash_macros.svh"
module skbh_ctrl import skbh_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic in_last,
  input  logic in_klen_nz,
  input  logic out_stall,
  output logic out_valid,
  output cmd_t cmd,
  input  sts_t sts
);
  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001, S_LANE = 8'b00000010, S_FIN = 8'b00000100,
    S_TAIL = 8'b00001000, S_AV   = 8'b00010000, S_MOD = 8'b00100000,
    S_OUT  = 8'b01000000, S_CHK  = 8'b10000000
  } st_t;
  st_t st_r, st_nxt;
  logic ph_r, ph_nxt, last_r, last_nxt;
  logic [1:0] ln_r, ln_nxt;
  logic [3:0] fill_at_fin_r;

  always_comb begin
    st_nxt = st_r; ph_nxt = ph_r; ln_nxt = ln_r; last_nxt = last_r;
    cmd = '0; cmd.op = OP_LANE;
    in_stall = 1'b1; out_valid = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_byte = 1'b1; last_nxt = in_last;
          st_nxt = S_CHK;
          if (!in_last && !in_klen_nz) st_nxt = S_IDLE;
        end
      end
      S_CHK: begin
        if (sts.stripe_full) st_nxt = S_LANE;
        else if (last_r) st_nxt = S_FIN;
        else st_nxt = S_IDLE;
        ln_nxt = '0;
      end
      S_LANE: begin
        cmd.op = OP_LANE; cmd.lane = ln_r;
        cmd.mul_a = !ph_r; cmd.mul_b = ph_r; ph_nxt = !ph_r;
        if (ph_r) begin
          ln_nxt = ln_r + 2'd1;
          if (ln_r == 2'd3) st_nxt = last_r ? S_FIN : S_IDLE;
        end
      end
      S_FIN: begin cmd.fin_start = 1'b1; ph_nxt = 1'b0; st_nxt = S_TAIL; end
      S_TAIL: begin
        if ({1'b0, sts.tail_p} + 5'd4 <= {1'b0, fill_at_fin_r}) cmd.op = OP_WORD;
        else cmd.op = OP_BYTE;
        if (sts.tail_p >= fill_at_fin_r) begin
          st_nxt = S_AV; ph_nxt = 1'b0;
        end else begin
          cmd.mul_a = !ph_r; cmd.mul_b = ph_r; cmd.tail_adv = ph_r; ph_nxt = !ph_r;
        end
      end
      S_AV: begin
        cmd.op = ph_r ? OP_AV2 : OP_AV1; cmd.mul_a = 1'b1; ph_nxt = !ph_r;
        if (ph_r) st_nxt = S_MOD;
      end
      S_MOD: begin
        if (!ph_r) begin cmd.av_last = 1'b1; ph_nxt = 1'b1; end
        else if (ln_r == 2'd0) begin cmd.mod_start = 1'b1; ln_nxt = 2'd1; end
        else if (!sts.mod_done && sts.want_mod) cmd.mod_step = 1'b1;
        else begin st_nxt = S_OUT; ph_nxt = 1'b0; ln_nxt = '0; end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin cmd.key_clear = 1'b1; st_nxt = S_IDLE; end
      end
      default: st_nxt = S_IDLE;
    endcase
    if (st_r == S_IDLE && in_valid) ph_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ph_r <= 1'b0; ln_r <= '0; last_r <= 1'b0;
    end else begin
      st_r <= st_nxt; ph_r <= ph_nxt; ln_r <= ln_nxt; last_r <= last_nxt;
    end
    if (cmd.fin_start) fill_at_fin_r <= sts.fill;
  end

  `SKBH_ASSERT_IMP(a_no_in_busy, clk, rst_n, st_r != S_IDLE, in_stall, "input taken while busy")
  `SKBH_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "result dropped")
  `SKBH_ASSERT_IMP(a_one_mul, clk, rst_n, 1'b1, !(cmd.mul_a && cmd.mul_b), "two multiply phases")
endmodule

@@ rtl/core/string_key_bucket_hash.sv @@
// ----------------------------------------------------------------------------
// string_key_bucket_hash
// Byte-serial XXH32 (seed 0) bucket indexer with iterative modulo.
// ----------------------------------------------------------------------------
// One key byte is taken per item; a byte is accepted and then passes a stripe
// check, and each completed 16-byte stripe adds lane rounds through the
// single shared 32x32 multiplier (two multiply steps per lane). After the
// last byte come a setup step, the tail (4-byte words, then single bytes,
// each through the multiplier, plus an exit step), the avalanche multiplies,
// a digest latch step and a 45-step restoring modulo with a setup and an
// exit step. With a length error, an empty key or a zero bucket count the
// modulo steps are skipped. The user must write the bucket count over the
// cfg port only while no key is in flight; the block does not enforce this.
`timescale 1ns / 1ps
module string_key_bucket_hash import skbh_pkg::*; #(
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_key_byte,
  input  logic [15:0] in_key_length,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_bucket_index,
  output logic [31:0] out_xxh32_value,
  output logic        out_length_error,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);
  cmd_t cmd;
  sts_t sts;
  logic [31:0] tsize_r;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) tsize_r <= NUM_BUCKETS_RST;
    else if (cfg_valid) tsize_r <= cfg_data;
  end

  skbh_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_last(in_last_byte),
    .in_klen_nz(in_key_length != 16'd0), .out_stall, .out_valid, .cmd, .sts
  );

  skbh_datapath #(.LENGTH_BITS(LENGTH_BITS)) u_dp (
    .clk, .rst_n, .cmd, .sts, .byte_i(in_key_byte), .len_i(in_key_length),
    .num_buckets(tsize_r), .idx_o(out_bucket_index), .dig_o(out_xxh32_value),
    .err_o(out_length_error)
  );
endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the byte-serial XXH32 bucket indexer.
// ----------------------------------------------------------------------------
// Keys are streamed one byte per item, with random gaps on the input side and
// random stall on the result side. A local model of the hash predicts every
// result. Each result the block returns is checked field by field against the
// oldest prediction. Coverage comes from directed keys, a sweep over bucket
// count values and a long run of mostly well-formed random keys.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_top;
  import skbh_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 4000000;
  localparam int unsigned DRAIN_CYCLES = 120;
  localparam bit [31:0] K1 = 32'h9E3779B1;
  localparam bit [31:0] K2 = 32'h85EBCA77;
  localparam bit [31:0] K3 = 32'hC2B2AE3D;
  localparam bit [31:0] K4 = 32'h27D4EB2F;
  localparam bit [31:0] K5 = 32'h165667B1;
  localparam bit [15:0] SEEN_MAX = 16'hFFFF;

  typedef struct {
    bit [31:0] index;
    bit [31:0] digest;
    bit        len_err;
  } bucket_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_key_byte = '0;
  logic [15:0] in_key_length = '0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_bucket_index;
  logic [31:0] out_xxh32_value;
  logic        out_length_error;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  // local copy of the hash state
  bit [31:0] lane_acc [4];
  bit [7:0]  stripe_buf [16];
  bit [15:0] bytes_cnt;
  bit [7:0]  first_b;
  bit [7:0]  mid_b;
  int unsigned fill_cnt;
  bit        stripe_done;
  bit        cnt_sat;
  bit [31:0] buckets;

  bucket_result_t bucket_results_q [$];
  bucket_result_t got_result;
  bucket_result_t want_result;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  bit          quiet = 1'b0;

  string_key_bucket_hash i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_key_byte      (in_key_byte),
    .in_key_length    (in_key_length),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_bucket_index (out_bucket_index),
    .out_xxh32_value  (out_xxh32_value),
    .out_length_error (out_length_error),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic bit [31:0] rot_left(input bit [31:0] x, input int unsigned r);
    return (x << r) | (x >> (32 - r));
  endfunction

  function automatic bit [31:0] stripe_word(input int unsigned i);
    return {stripe_buf[(i + 3) & 15], stripe_buf[(i + 2) & 15],
            stripe_buf[(i + 1) & 15], stripe_buf[i & 15]};
  endfunction

  task automatic clear_key_state();
    lane_acc[0] = K1 + K2;
    lane_acc[1] = K2;
    lane_acc[2] = 32'd0;
    lane_acc[3] = 32'd0 - K1;
    foreach (stripe_buf[i]) stripe_buf[i] = 8'd0;
    bytes_cnt = '0;
    first_b = '0;
    mid_b = '0;
    fill_cnt = 0;
    stripe_done = 1'b0;
    cnt_sat = 1'b0;
  endtask

  function automatic bit [31:0] key_digest();
    bit [31:0] h;
    int unsigned p;
    p = 0;
    if (stripe_done)
      h = rot_left(lane_acc[0], 1) + rot_left(lane_acc[1], 7)
        + rot_left(lane_acc[2], 12) + rot_left(lane_acc[3], 18);
    else
      h = K5;
    h = h + {16'd0, bytes_cnt};
    while (p + 4 <= fill_cnt) begin
      h = h + stripe_word(p) * K3;
      h = rot_left(h, 17) * K4;
      p += 4;
    end
    while (p < fill_cnt) begin
      h = h + {24'd0, stripe_buf[p & 15]} * K5;
      h = rot_left(h, 11) * K1;
      p++;
    end
    h = h ^ (h >> 15);
    h = h * K2;
    h = h ^ (h >> 13);
    h = h * K3;
    h = h ^ (h >> 16);
    return h;
  endfunction

  // Advance the local hash by one accepted item; queue a result at key end.
  task automatic predict_bucket(input bit [7:0] b, input bit [15:0] klen, input bit last);
    bucket_result_t r;
    bit [63:0] combined;
    if (klen != 0) begin
      if (bytes_cnt == 0 && !cnt_sat) first_b = b;
      if (!cnt_sat && bytes_cnt == klen / 2) mid_b = b;
      stripe_buf[fill_cnt & 15] = b;
      fill_cnt++;
      if (fill_cnt == 16) begin
        for (int k = 0; k < 4; k++)
          lane_acc[k] = rot_left(lane_acc[k] + stripe_word(4 * k) * K2, 13) * K1;
        fill_cnt = 0;
        stripe_done = 1'b1;
      end
      if (bytes_cnt == SEEN_MAX) cnt_sat = 1'b1;
      else bytes_cnt++;
    end
    if (last) begin
      r.digest = key_digest();
      r.len_err = cnt_sat || (bytes_cnt != klen);
      r.index = '0;
      if (!r.len_err && klen != 0 && buckets != 0) begin
        combined = ({56'd0, first_b} * 961 + {56'd0, mid_b} * 31 + {56'd0, b}) * 31
                 + {32'd0, r.digest};
        r.index = 32'(combined % {32'd0, buckets});
      end
      bucket_results_q.push_back(r);
      clear_key_state();
    end
  endtask

  task automatic report_mismatch(input string what, input bit [31:0] got, input bit [31:0] want);
    $display("[%0t] mismatch %s: got %h want %h", $realtime, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_result.index = out_bucket_index;
      got_result.digest = out_xxh32_value;
      got_result.len_err = out_length_error;
      if (bucket_results_q.size() == 0) begin
        report_mismatch("unexpected result", out_bucket_index, 32'd0);
      end else begin
        want_result = bucket_results_q.pop_front();
        if (got_result.index != want_result.index)
          report_mismatch("bucket_index", got_result.index, want_result.index);
        if (got_result.digest != want_result.digest)
          report_mismatch("xxh32_value", got_result.digest, want_result.digest);
        if (got_result.len_err != want_result.len_err)
          report_mismatch("length_error", got_result.len_err, want_result.len_err);
      end
    end
    out_stall <= !quiet && ($urandom_range(99) < 31);
  end

  // Send one item; valid stays high afterwards so back-to-back items need no gap.
  task automatic send_item(input bit [7:0] b, input bit [15:0] klen, input bit last);
    if (!quiet && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_key_byte <= b;
    in_key_length <= klen;
    in_last_byte <= last;
    do @(posedge clk); while (in_stall);
    predict_bucket(b, klen, last);
    items_sent++;
  endtask

  // nbytes bytes tagged with klen, last mark on the final one
  task automatic send_key(input bit [15:0] klen, input int unsigned nbytes);
    if (nbytes == 0) send_item(8'($urandom), 16'd0, 1'b1);
    for (int unsigned i = 0; i < nbytes; i++)
      send_item(8'($urandom), klen, i == nbytes - 1);
  endtask

  task automatic wait_results_idle();
    in_valid <= 1'b0;
    while (bucket_results_q.size() != 0) @(posedge clk);
    // a length-0 item without last can leave no result to wait on
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_bucket_count(input bit [31:0] value);
    wait_results_idle();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    buckets = value;
  endtask

  task automatic test_directed_keys();
    send_key(16'd0, 0);                      // empty key, nothing before it
    send_item(8'h00, 16'd1, 1'b1);
    send_item(8'hFF, 16'd1, 1'b1);
    send_key(16'd4, 4);                      // one tail word
    send_key(16'd16, 16);                    // exactly one stripe
    send_item(8'hA5, 16'd0, 1'b0);           // empty item without last: no effect
    send_key(16'd3, 3);
    send_key(16'd5, 2);                      // short key, middle byte never reached
    send_key(16'd2, 4);                      // long key
    send_item(8'h11, 16'd6, 1'b0);           // length changes within the key
    send_item(8'h22, 16'd2, 1'b1);
    send_item(8'h33, 16'd3, 1'b0);           // bytes followed by an empty item
    send_item(8'h44, 16'd3, 1'b0);
    send_item(8'h55, 16'd0, 1'b1);
    send_key(16'hFFFF, 2);
  endtask

  task automatic test_bucket_counts();
    bit [31:0] sizes [7];
    int unsigned len;
    sizes = '{32'd1, 32'hFFFFFFFF, 32'd0, 32'd31, 32'h80000000, $urandom, 32'd83231};
    foreach (sizes[i]) begin
      write_bucket_count(sizes[i]);
      repeat (6) begin
        send_key(16'd0, 0);
        len = $urandom_range(1, 24);
        send_key(16'(len), len);
      end
    end
  endtask

  task automatic test_random_keys();
    int unsigned len;
    int unsigned pick;
    int unsigned next_pause;
    int unsigned quiet_end;
    quiet_end = items_sent + 250;
    next_pause = items_sent + 300;
    quiet = 1'b1;
    while (items_sent < 1250) begin
      if (items_sent > quiet_end) quiet = 1'b0;
      if (items_sent >= next_pause) begin
        // hold the sender until every pending result is out
        in_valid <= 1'b0;
        while (bucket_results_q.size() != 0) @(posedge clk);
        next_pause += 300;
      end
      pick = $urandom_range(99);
      if (pick < 80) begin
        if ($urandom_range(19) == 0) len = 0;
        else if ($urandom_range(9) == 0) len = $urandom_range(40, 200);
        else len = $urandom_range(1, 40);
        send_key(16'(len), len);
      end else if (pick < 90) begin
        send_key(16'($urandom), $urandom_range(0, 20));
      end else begin
        send_item(8'($urandom), 16'($urandom), 1'($urandom_range(1)));
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    buckets = 32'd83231;
    clear_key_state();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_keys();
    test_bucket_counts();
    test_random_keys();
    wait_results_idle();
    if (error_count == 0 && bucket_results_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

@@ string_key_bucket_hash.f @@
+incdir+rtl/core
rtl/core/skbh_pkg.sv
rtl/core/skbh_datapath.sv
rtl/core/skbh_ctrl.sv
rtl/core/string_key_bucket_hash.sv
tb/sv/tb_top.sv
